FILE: hw/rtl/fmg_pkg.sv
package fmg_pkg;

  localparam int MAX_SLICES_DEF = 256;
  localparam int ANGLE_BITS_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS,
    REG_HEIGHT,
    REG_TAPER,
    REG_SLICE_COUNT,
    REG_SOLID_CAPS,
    REG_TEX_ENABLE
  } reg_idx_t;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_TEXCOORD = 2'd2;
  localparam logic [1:0] KIND_TEXTRI   = 2'd3;

  // q30 fixed point
  localparam logic [30:0] ONE30       = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [31:0] COORD_ONE  = 32'h0001_0000;
  localparam logic [31:0] COORD_HALF = 32'h0000_8000;

  // horner divisors, innermost term first
  localparam int SIN_CELLS = 4;
  localparam int COS_CELLS = 5;
  localparam int SIN_DIV [SIN_CELLS] = '{72, 42, 20, 6};
  localparam int COS_DIV [COS_CELLS] = '{90, 56, 30, 12, 2};

  typedef struct packed {
    logic [7:0]  idx;
    logic [16:0] uu;
    logic [1:0]  quad;
    logic        fold;
    logic [29:0] x;
    logic        cn;
    logic        sn;
    logic [16:0] cu;
    logic [16:0] cv;
  } ctx_t;

  typedef enum logic [4:0] {
    E_CTR_BOT,
    E_CTR_TOP,
    E_CTR_TEX,
    E_VTX_BOT,
    E_VTX_TOP,
    E_SIDE0,
    E_SIDE1,
    E_CAP0,
    E_CAP1,
    E_TEX_LO,
    E_TEX_HI,
    E_TTRI0,
    E_TTRI1,
    E_TEX_CAP,
    E_TTRI2,
    E_TTRI3,
    E_SEAM_LO,
    E_SEAM_HI,
    E_SEAM_MID
  } entry_t;

  localparam int NUM_ENTRIES = 19;

endpackage

FILE: hw/rtl/fmg_if.sv
interface fmg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] slice;

  modport source (output valid, output slice, input ready);
  modport sink (input valid, input slice, output ready);
endinterface

interface fmg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [9:0]         slot;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [9:0]         corner_a;
  logic [9:0]         corner_b;
  logic [9:0]         corner_c;
  logic               last;

  modport source (output valid, output kind, output slot, output coord_x, output coord_y,
                  output coord_z, output corner_a, output corner_b, output corner_c,
                  output last, input ready);
  modport sink (input valid, input kind, input slot, input coord_x, input coord_y,
                input coord_z, input corner_a, input corner_b, input corner_c,
                input last, output ready);
endinterface

FILE: hw/rtl/fmg_div_cell.sv
module fmg_div_cell #(
  parameter int SW = 9,
  parameter int FB = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] divisor,
  input  logic [SW-1:0] rem_in,
  input  logic [FB-1:0] quot_in,
  output logic [SW-1:0] rem_out,
  output logic [FB-1:0] quot_out
);

  logic [SW:0]   dbl;
  logic [SW:0]   diff;
  logic          ge;
  logic [SW-1:0] rem_r;
  logic [FB-1:0] quot_r;

  // one restoring step: one quotient bit per cell
  assign dbl  = {rem_in, 1'b0};
  assign diff = dbl - {1'b0, divisor};
  assign ge   = dbl >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? diff[SW-1:0] : dbl[SW-1:0];
      quot_r <= {quot_in[FB-2:0], ge};
    end
  end

  assign rem_out  = rem_r;
  assign quot_out = quot_r;

endmodule

FILE: hw/rtl/fmg_horner_cell.sv
module fmg_horner_cell #(
  parameter int DIVISOR = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] acc_in,
  input  logic [29:0] x2_in,
  output logic [30:0] acc_out,
  output logic [29:0] x2_out
);

  // exact reciprocal for dividends below 2^31
  localparam int SHIFT = 31 + $clog2(DIVISOR);
  localparam logic [31:0] MAGIC =
    32'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [60:0] prod_a;
  logic [61:0] prod_b;
  logic [29:0] v_r;
  logic [29:0] q_r;
  logic [29:0] x2a_r;
  logic [29:0] x2b_r;

  assign prod_a = 61'(x2_in) * 61'(acc_in);
  assign prod_b = 62'(v_r) * 62'(MAGIC);

  always_ff @(posedge clk) begin
    if (en) begin
      v_r   <= prod_a[59:30];
      x2a_r <= x2_in;
      q_r   <= 30'(prod_b >> SHIFT);
      x2b_r <= x2a_r;
    end
  end

  assign acc_out = fmg_pkg::ONE30 - {1'b0, q_r};
  assign x2_out  = x2b_r;

endmodule

FILE: hw/rtl/frustum_mesh_generator.sv
// Frustum mesh generator: each accepted slice index runs through a pipeline in which a
// chain of restoring divider cells forms the slice angle, two chains of Horner
// cells form cos and sin, then the radius and taper products. A sequencer then
// sends the slice's 4 to 19 results out (13 with caps and texturing, 16 on the
// first and last slice), one per cycle while the result channel does not stall,
// so the result channel sets the sustained rate. A new slice is taken while the
// previous one is still going out. Slices not below the effective slice count are
// taken and give no results.
module frustum_mesh_generator #(
  parameter int MAX_SLICES = fmg_pkg::MAX_SLICES_DEF,
  parameter int ANGLE_BITS = fmg_pkg::ANGLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fmg_in_if.sink                          in_ch,
  fmg_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [fmg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fmg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SW   = $clog2(MAX_SLICES + 1);
  localparam int CW   = (SW > 9) ? SW : 9;
  localparam int FB   = ((ANGLE_BITS > 16) ? ANGLE_BITS : 16) + 1;
  localparam int XW   = ANGLE_BITS - 2;
  localparam int PW   = ANGLE_BITS + 1;
  localparam int T_PH = FB + 1;
  localparam int T_X  = FB + 2;
  localparam int T_X2 = FB + 3;
  localparam int T_SN = T_X2 + 2 * fmg_pkg::SIN_CELLS;
  localparam int T_CS = T_X2 + 2 * fmg_pkg::COS_CELLS;
  localparam int T_QS = T_CS + 1;
  localparam int T_M  = T_QS + 1;
  localparam int T_T  = T_M + 1;
  localparam int T_R  = T_T + 1;

  // configuration registers
  logic [23:0] radius_r;
  logic [23:0] height_r;
  logic [17:0] taper_r;
  logic [8:0]  slice_count_r;
  logic        solid_r;
  logic        tex_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= 24'd65536;
      height_r      <= 24'd65536;
      taper_r       <= 18'd65536;
      slice_count_r <= 9'd8;
      solid_r       <= 1'b1;
      tex_r         <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        fmg_pkg::REG_RADIUS:      radius_r      <= cfg_data;
        fmg_pkg::REG_HEIGHT:      height_r      <= cfg_data;
        fmg_pkg::REG_TAPER:       taper_r       <= cfg_data[17:0];
        fmg_pkg::REG_SLICE_COUNT: slice_count_r <= cfg_data[8:0];
        fmg_pkg::REG_SOLID_CAPS:  solid_r       <= cfg_data[0];
        fmg_pkg::REG_TEX_ENABLE:  tex_r         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [CW-1:0] sc_ext;
  logic [CW-1:0] s_eff;
  logic [SW-1:0] s_div;
  logic          in_range;

  assign sc_ext   = CW'(slice_count_r);
  assign s_eff    = (sc_ext == '0) ? CW'(1) :
                    (sc_ext > CW'(MAX_SLICES)) ? CW'(MAX_SLICES) : sc_ext;
  assign s_div    = s_eff[SW-1:0];
  assign in_range = CW'(in_ch.slice) < s_eff;

  // pipeline control
  logic             en;
  logic             load;
  logic [T_R:0]     v_r;
  fmg_pkg::ctx_t    ctx_r   [0:T_R];
  fmg_pkg::ctx_t    ctx_nxt [1:T_R];
  fmg_pkg::ctx_t    ctx_in;

  assign en          = !v_r[T_R] || load;
  assign in_ch.ready = en;

  always_comb begin
    ctx_in     = '0;
    ctx_in.idx = in_ch.slice;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[T_R-1:0], in_ch.valid && in_range};
    end
  end

  // divider chain: Q = floor(i * 2^FB / S)
  logic [SW-1:0] rem_w  [0:FB];
  logic [FB-1:0] quot_w [0:FB];

  assign rem_w[0]  = SW'(ctx_r[0].idx);
  assign quot_w[0] = '0;

  for (genvar g = 0; g < FB; g++) begin : g_div
    fmg_div_cell #(.SW(SW), .FB(FB)) u_cell (
      .clk      (clk),
      .en       (en),
      .divisor  (s_div),
      .rem_in   (rem_w[g]),
      .quot_in  (quot_w[g]),
      .rem_out  (rem_w[g+1]),
      .quot_out (quot_w[g+1])
    );
  end

  // rounded phase and texture u from the fine quotient
  logic [PW-1:0]   ph_t;
  logic [PW:0]     ph_p;
  logic [ANGLE_BITS-1:0] phase;
  logic [16:0]     u_t;
  logic [17:0]     u_p;
  logic [XW-1:0]   ph_rem;
  logic [XW:0]     ph_fold;
  logic            fold;
  logic [XW-1:0]   xi_r;

  assign ph_t    = PW'(quot_w[FB] >> (FB - ANGLE_BITS - 1));
  assign ph_p    = {1'b0, ph_t} + (PW+1)'(1);
  assign phase   = ph_p[ANGLE_BITS:1];
  assign u_t     = 17'(quot_w[FB] >> (FB - 17));
  assign u_p     = {1'b0, u_t} + 18'd1;
  assign ph_rem  = phase[XW-1:0];
  assign fold    = ph_rem > XW'(1 << (XW - 1));
  assign ph_fold = {1'b1, {XW{1'b0}}} - {1'b0, ph_rem};

  always_ff @(posedge clk) begin
    if (en) begin
      xi_r <= fold ? ph_fold[XW-1:0] : ph_rem;
    end
  end

  logic [XW+30:0] prod_x;
  logic [29:0]    x_v;
  logic [59:0]    prod_x2;
  logic [29:0]    x2_r;

  assign prod_x  = (XW+31)'(xi_r) * (XW+31)'(fmg_pkg::HALF_PI_Q30);
  assign x_v     = 30'(prod_x >> XW);
  assign prod_x2 = 60'(ctx_r[T_X].x) * 60'(ctx_r[T_X].x);

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= prod_x2[59:30];
    end
  end

  // horner chains
  logic [30:0] sa [0:fmg_pkg::SIN_CELLS];
  logic [29:0] sx [0:fmg_pkg::SIN_CELLS];
  logic [30:0] ca [0:fmg_pkg::COS_CELLS];
  logic [29:0] cx [0:fmg_pkg::COS_CELLS];

  assign sa[0] = fmg_pkg::ONE30;
  assign sx[0] = x2_r;
  assign ca[0] = fmg_pkg::ONE30;
  assign cx[0] = x2_r;

  for (genvar g = 0; g < fmg_pkg::SIN_CELLS; g++) begin : g_sin
    fmg_horner_cell #(.DIVISOR(fmg_pkg::SIN_DIV[g])) u_cell (
      .clk (clk), .en (en),
      .acc_in (sa[g]), .x2_in (sx[g]), .acc_out (sa[g+1]), .x2_out (sx[g+1])
    );
  end

  for (genvar g = 0; g < fmg_pkg::COS_CELLS; g++) begin : g_cos
    fmg_horner_cell #(.DIVISOR(fmg_pkg::COS_DIV[g])) u_cell (
      .clk (clk), .en (en),
      .acc_in (ca[g]), .x2_in (cx[g]), .acc_out (ca[g+1]), .x2_out (cx[g+1])
    );
  end

  logic [60:0] prod_s;
  logic [30:0] s_r;
  logic [30:0] s_d_r;

  assign prod_s = 61'(ctx_r[T_SN].x) * 61'(sa[fmg_pkg::SIN_CELLS]);

  always_ff @(posedge clk) begin
    if (en) begin
      s_r   <= prod_s[60:30];
      s_d_r <= s_r;
    end
  end

  // quadrant mapping
  logic [30:0] sp;
  logic [30:0] cp;
  logic [30:0] cm_v;
  logic [30:0] sm_v;
  logic        cn_v;
  logic        sn_v;
  logic [30:0] cm_r;
  logic [30:0] sm_r;

  assign sp = ctx_r[T_CS].fold ? ca[fmg_pkg::COS_CELLS] : s_d_r;
  assign cp = ctx_r[T_CS].fold ? s_d_r : ca[fmg_pkg::COS_CELLS];

  always_comb begin
    case (ctx_r[T_CS].quad)
      2'd0: begin cm_v = cp; cn_v = 1'b0; sm_v = sp; sn_v = 1'b0; end
      2'd1: begin cm_v = sp; cn_v = 1'b1; sm_v = cp; sn_v = 1'b0; end
      2'd2: begin cm_v = cp; cn_v = 1'b1; sm_v = sp; sn_v = 1'b1; end
      default: begin cm_v = sp; cn_v = 1'b0; sm_v = cp; sn_v = 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cm_r <= cm_v;
      sm_r <= sm_v;
    end
  end

  // radius scaling and cap texture values
  logic [54:0] pm_c;
  logic [54:0] pm_s;
  logic [40:0] mc_r;
  logic [40:0] ms_r;
  logic [31:0] cu_sum;
  logic [31:0] cv_sum;

  assign pm_c = 55'(cm_r) * 55'(radius_r);
  assign pm_s = 55'(sm_r) * 55'(radius_r);
  assign cu_sum = (ctx_r[T_QS].cn ? ({1'b0, fmg_pkg::ONE30} - {1'b0, cm_r})
                                  : ({1'b0, fmg_pkg::ONE30} + {1'b0, cm_r})) + 32'h4000;
  assign cv_sum = (ctx_r[T_QS].sn ? ({1'b0, fmg_pkg::ONE30} - {1'b0, sm_r})
                                  : ({1'b0, fmg_pkg::ONE30} + {1'b0, sm_r})) + 32'h4000;

  always_ff @(posedge clk) begin
    if (en) begin
      mc_r <= pm_c[54:14];
      ms_r <= pm_s[54:14];
    end
  end

  logic [41:0] bx_rnd;
  logic [41:0] by_rnd;
  logic [25:0] bxm_r;
  logic [25:0] bym_r;
  logic [58:0] tpx_r;
  logic [58:0] tpy_r;

  assign bx_rnd = {1'b0, mc_r} + 42'h8000;
  assign by_rnd = {1'b0, ms_r} + 42'h8000;

  always_ff @(posedge clk) begin
    if (en) begin
      bxm_r <= bx_rnd[41:16];
      bym_r <= by_rnd[41:16];
      tpx_r <= 59'(mc_r) * 59'(taper_r);
      tpy_r <= 59'(ms_r) * 59'(taper_r);
    end
  end

  logic [59:0]        tx_rnd;
  logic [59:0]        ty_rnd;
  logic signed [31:0] bx_r;
  logic signed [31:0] by_r;
  logic signed [31:0] tx_r;
  logic signed [31:0] ty_r;

  assign tx_rnd = {1'b0, tpx_r} + 60'h8000_0000;
  assign ty_rnd = {1'b0, tpy_r} + 60'h8000_0000;

  always_ff @(posedge clk) begin
    if (en) begin
      bx_r <= ctx_r[T_T].cn ? -32'(bxm_r) : 32'(bxm_r);
      by_r <= ctx_r[T_T].sn ? -32'(bym_r) : 32'(bym_r);
      tx_r <= ctx_r[T_T].cn ? -32'(tx_rnd[59:32]) : 32'(tx_rnd[59:32]);
      ty_r <= ctx_r[T_T].sn ? -32'(ty_rnd[59:32]) : 32'(ty_rnd[59:32]);
    end
  end

  // context line, fields filled in at the stage that produces them
  always_comb begin
    for (int k = 1; k <= T_R; k++) begin
      ctx_nxt[k] = ctx_r[k-1];
    end
    ctx_nxt[T_PH].uu   = u_p[17:1];
    ctx_nxt[T_PH].quad = phase[ANGLE_BITS-1:ANGLE_BITS-2];
    ctx_nxt[T_PH].fold = fold;
    ctx_nxt[T_X].x     = x_v;
    ctx_nxt[T_QS].cn   = cn_v;
    ctx_nxt[T_QS].sn   = sn_v;
    ctx_nxt[T_M].cu    = cu_sum[31:15];
    ctx_nxt[T_M].cv    = cv_sum[31:15];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_r[0] <= ctx_in;
      for (int k = 1; k <= T_R; k++) begin
        ctx_r[k] <= ctx_nxt[k];
      end
    end
  end

  // result sequencer
  logic               busy_r;
  fmg_pkg::entry_t    entry_r;
  logic [7:0]         rec_idx_r;
  logic [16:0]        rec_uu_r;
  logic [16:0]        rec_cu_r;
  logic [16:0]        rec_cv_r;
  logic signed [31:0] rec_bx_r;
  logic signed [31:0] rec_by_r;
  logic signed [31:0] rec_tx_r;
  logic signed [31:0] rec_ty_r;

  logic [fmg_pkg::NUM_ENTRIES-1:0] ena;
  logic [fmg_pkg::NUM_ENTRIES-1:0] later;
  fmg_pkg::entry_t                 nxt_e;
  fmg_pkg::entry_t                 first_e;
  logic                            has_next;
  logic                            first_slice;
  logic                            last_slice;
  logic                            out_free;
  logic                            emit;
  logic                            done;

  assign first_slice = (rec_idx_r == 8'd0) && solid_r;
  assign last_slice  = CW'(rec_idx_r) == (s_eff - CW'(1));

  always_comb begin
    ena = '0;
    ena[fmg_pkg::E_CTR_BOT]  = first_slice;
    ena[fmg_pkg::E_CTR_TOP]  = first_slice;
    ena[fmg_pkg::E_CTR_TEX]  = first_slice && tex_r;
    ena[fmg_pkg::E_VTX_BOT]  = 1'b1;
    ena[fmg_pkg::E_VTX_TOP]  = 1'b1;
    ena[fmg_pkg::E_SIDE0]    = 1'b1;
    ena[fmg_pkg::E_SIDE1]    = 1'b1;
    ena[fmg_pkg::E_CAP0]     = solid_r;
    ena[fmg_pkg::E_CAP1]     = solid_r;
    ena[fmg_pkg::E_TEX_LO]   = tex_r;
    ena[fmg_pkg::E_TEX_HI]   = tex_r;
    ena[fmg_pkg::E_TTRI0]    = tex_r;
    ena[fmg_pkg::E_TTRI1]    = tex_r;
    ena[fmg_pkg::E_TEX_CAP]  = tex_r && solid_r;
    ena[fmg_pkg::E_TTRI2]    = tex_r && solid_r;
    ena[fmg_pkg::E_TTRI3]    = tex_r && solid_r;
    ena[fmg_pkg::E_SEAM_LO]  = tex_r && last_slice;
    ena[fmg_pkg::E_SEAM_HI]  = tex_r && last_slice;
    ena[fmg_pkg::E_SEAM_MID] = tex_r && last_slice && solid_r;
  end

  always_comb begin
    nxt_e = fmg_pkg::E_CTR_BOT;
    for (int k = 0; k < fmg_pkg::NUM_ENTRIES; k++) begin
      later[k] = ena[k] && (5'(k) > entry_r);
    end
    for (int k = fmg_pkg::NUM_ENTRIES - 1; k >= 0; k--) begin
      if (later[k]) begin
        nxt_e = fmg_pkg::entry_t'(5'(k));
      end
    end
    has_next = |later;
  end

  assign first_e  = ((ctx_r[T_R].idx == 8'd0) && solid_r) ? fmg_pkg::E_CTR_BOT
                                                           : fmg_pkg::E_VTX_BOT;
  assign out_free = !out_ch.valid || out_ch.ready;
  assign emit     = busy_r && out_free;
  assign done     = emit && !has_next;
  assign load     = v_r[T_R] && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      entry_r <= fmg_pkg::E_CTR_BOT;
    end else if (load) begin
      busy_r  <= 1'b1;
      entry_r <= first_e;
    end else begin
      if (done) begin
        busy_r <= 1'b0;
      end
      if (emit) begin
        entry_r <= nxt_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec_idx_r <= ctx_r[T_R].idx;
      rec_uu_r  <= ctx_r[T_R].uu;
      rec_cu_r  <= ctx_r[T_R].cu;
      rec_cv_r  <= ctx_r[T_R].cv;
      rec_bx_r  <= bx_r;
      rec_by_r  <= by_r;
      rec_tx_r  <= tx_r;
      rec_ty_r  <= ty_r;
    end
  end

  // list positions, all modulo 1024
  logic [9:0] i10;
  logic [9:0] s10;
  logic [9:0] two_s;
  logic [9:0] cur;
  logic [9:0] nxt;
  logic [9:0] step10;
  logic [9:0] ts;
  logic [9:0] ct;
  logic [9:0] nt;
  logic [9:0] basetex;
  logic [9:0] sb;

  assign i10     = 10'(rec_idx_r);
  assign s10     = 10'(s_eff);
  assign two_s   = {s10[8:0], 1'b0};
  assign cur     = {i10[8:0], 1'b0};
  assign nxt     = last_slice ? 10'd0 : cur + 10'd2;
  assign step10  = solid_r ? 10'd3 : 10'd2;
  assign ts      = solid_r ? {i10[7:0], 2'b00} : cur;
  assign ct      = solid_r ? cur + i10 : cur;
  assign nt      = ct + step10;
  assign basetex = solid_r ? ({s10[8:0], 1'b0} + s10 + 10'd3) : (two_s + 10'd2);
  assign sb      = solid_r ? (two_s + s10) : two_s;

  logic [1:0]         p_kind;
  logic [9:0]         p_slot;
  logic signed [31:0] p_x;
  logic signed [31:0] p_y;
  logic signed [31:0] p_z;
  logic [9:0]         p_a;
  logic [9:0]         p_b;
  logic [9:0]         p_c;

  always_comb begin
    p_kind = fmg_pkg::KIND_VERTEX;
    p_slot = '0;
    p_x    = '0;
    p_y    = '0;
    p_z    = '0;
    p_a    = '0;
    p_b    = '0;
    p_c    = '0;
    case (entry_r)
      fmg_pkg::E_CTR_BOT: begin
        p_slot = two_s;
      end
      fmg_pkg::E_CTR_TOP: begin
        p_slot = two_s + 10'd1;
        p_z    = 32'(height_r);
      end
      fmg_pkg::E_CTR_TEX: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = basetex;
        p_x    = fmg_pkg::COORD_HALF;
        p_y    = fmg_pkg::COORD_HALF;
      end
      fmg_pkg::E_VTX_BOT: begin
        p_slot = cur;
        p_x    = rec_bx_r;
        p_y    = rec_by_r;
      end
      fmg_pkg::E_VTX_TOP: begin
        p_slot = cur + 10'd1;
        p_x    = rec_tx_r;
        p_y    = rec_ty_r;
        p_z    = 32'(height_r);
      end
      fmg_pkg::E_SIDE0: begin
        p_kind = fmg_pkg::KIND_TRIANGLE;
        p_slot = ts;
        p_a = cur; p_b = nxt; p_c = cur + 10'd1;
      end
      fmg_pkg::E_SIDE1: begin
        p_kind = fmg_pkg::KIND_TRIANGLE;
        p_slot = ts + 10'd1;
        p_a = cur + 10'd1; p_b = nxt; p_c = nxt + 10'd1;
      end
      fmg_pkg::E_CAP0: begin
        p_kind = fmg_pkg::KIND_TRIANGLE;
        p_slot = ts + 10'd2;
        p_a = cur + 10'd1; p_b = nxt + 10'd1; p_c = two_s + 10'd1;
      end
      fmg_pkg::E_CAP1: begin
        p_kind = fmg_pkg::KIND_TRIANGLE;
        p_slot = ts + 10'd3;
        p_a = cur; p_b = two_s; p_c = nxt;
      end
      fmg_pkg::E_TEX_LO: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = ct;
        p_x    = 32'(rec_uu_r);
      end
      fmg_pkg::E_TEX_HI: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = ct + 10'd1;
        p_x    = 32'(rec_uu_r);
        p_y    = fmg_pkg::COORD_ONE;
      end
      fmg_pkg::E_TTRI0: begin
        p_kind = fmg_pkg::KIND_TEXTRI;
        p_slot = ts;
        p_a = ct; p_b = nt; p_c = ct + 10'd1;
      end
      fmg_pkg::E_TTRI1: begin
        p_kind = fmg_pkg::KIND_TEXTRI;
        p_slot = ts + 10'd1;
        p_a = ct + 10'd1; p_b = nt; p_c = nt + 10'd1;
      end
      fmg_pkg::E_TEX_CAP: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = ct + 10'd2;
        p_x    = 32'(rec_cu_r);
        p_y    = 32'(rec_cv_r);
      end
      fmg_pkg::E_TTRI2: begin
        p_kind = fmg_pkg::KIND_TEXTRI;
        p_slot = ts + 10'd2;
        p_a = ct + 10'd2; p_b = nt + 10'd2; p_c = basetex;
      end
      fmg_pkg::E_TTRI3: begin
        p_kind = fmg_pkg::KIND_TEXTRI;
        p_slot = ts + 10'd3;
        p_a = ct + 10'd2; p_b = basetex; p_c = nt + 10'd2;
      end
      fmg_pkg::E_SEAM_LO: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = sb;
        p_x    = fmg_pkg::COORD_ONE;
      end
      fmg_pkg::E_SEAM_HI: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = sb + 10'd1;
        p_x    = fmg_pkg::COORD_ONE;
        p_y    = fmg_pkg::COORD_ONE;
      end
      fmg_pkg::E_SEAM_MID: begin
        p_kind = fmg_pkg::KIND_TEXCOORD;
        p_slot = sb + 10'd2;
        p_x    = fmg_pkg::COORD_ONE;
        p_y    = fmg_pkg::COORD_HALF;
      end
      default: ;
    endcase
  end

  // output register
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [9:0]         out_slot_r;
  logic signed [31:0] out_x_r;
  logic signed [31:0] out_y_r;
  logic signed [31:0] out_z_r;
  logic [9:0]         out_a_r;
  logic [9:0]         out_b_r;
  logic [9:0]         out_c_r;
  logic               out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= p_kind;
      out_slot_r <= p_slot;
      out_x_r    <= p_x;
      out_y_r    <= p_y;
      out_z_r    <= p_z;
      out_a_r    <= p_a;
      out_b_r    <= p_b;
      out_c_r    <= p_c;
      out_last_r <= !has_next;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.slot     = out_slot_r;
  assign out_ch.coord_x  = out_x_r;
  assign out_ch.coord_y  = out_y_r;
  assign out_ch.coord_z  = out_z_r;
  assign out_ch.corner_a = out_a_r;
  assign out_ch.corner_b = out_b_r;
  assign out_ch.corner_c = out_c_r;
  assign out_ch.last     = out_last_r;

endmodule

FILE: hw/rtl/fmg_checker.sv
module fmg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_kind,
  input logic [9:0]         out_slot,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_z,
  input logic [9:0]         out_a,
  input logic [9:0]         out_b,
  input logic [9:0]         out_c,
  input logic               out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_kind, out_slot, out_x, out_y, out_z,
                                         out_a, out_b, out_c, out_last}))
    else $error("result changed while stalled");

  // point results carry no corners
  a_point_corners: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == fmg_pkg::KIND_VERTEX || out_kind == fmg_pkg::KIND_TEXCOORD)
    |-> out_a == 10'd0 && out_b == 10'd0 && out_c == 10'd0)
    else $error("corner set on a point result");

  // triangles carry no coordinates, texture points have no z
  a_tri_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != fmg_pkg::KIND_VERTEX |-> out_z == 32'sd0 &&
    (out_kind == fmg_pkg::KIND_TEXCOORD || (out_x == 32'sd0 && out_y == 32'sd0)))
    else $error("coordinate set on a triangle or texture result");

endmodule

bind frustum_mesh_generator fmg_checker u_fmg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_slot  (out_ch.slot),
  .out_x     (out_ch.coord_x),
  .out_y     (out_ch.coord_y),
  .out_z     (out_ch.coord_z),
  .out_a     (out_ch.corner_a),
  .out_b     (out_ch.corner_b),
  .out_c     (out_ch.corner_c),
  .out_last  (out_ch.last)
);
